// ===== src/akd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the analog keypad decoder.
package akd_pkg;

    // Sample and field widths
    localparam int ADC_BITS = 12;
    localparam int ADJ_W    = ADC_BITS + 2;
    localparam int DIST_W   = ADC_BITS + 1;
    localparam int OFF_W    = 10;
    localparam int CNT_W    = 8;
    localparam int GAP_W    = 16;
    localparam int TIME_W   = 32;
    localparam int CMD_W    = 2;
    localparam int CIDX_W   = 4;
    localparam int KEY_W    = 5;
    localparam int LEVEL_W  = 4;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 16;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [ADC_BITS-1:0] ADC_MAX   = {ADC_BITS{1'b1}};
    localparam logic [KEY_W-1:0]    NO_KEY    = 5'd16;
    localparam logic [CNT_W-1:0]    COUNT_CAP = 8'd250;

    // Defaults of the top level parameters
    localparam int DEF_NUM_KEYS    = 16;
    localparam int DEF_QUEUE_DEPTH = 8;

    // Register reset values
    localparam logic                RST_ENABLED  = 1'b1;
    localparam logic [OFF_W-1:0]    RST_OFFSET   = 10'd0;
    localparam logic [ADC_BITS-1:0] RST_BAND     = 12'd100;
    localparam logic [ADC_BITS-1:0] RST_NO_KEY   = 12'd4000;
    localparam logic                RST_IDLE_LOW = 1'b0;
    localparam logic [ADC_BITS-1:0] RST_TOL      = 12'd80;
    localparam logic [CNT_W-1:0]    RST_POLLS    = 8'd3;
    localparam logic [GAP_W-1:0]    RST_GAP      = 16'd200;

    // Factory calibration of the ladder, key 0 first
    localparam logic [ADC_BITS-1:0] DEFAULT_CENTERS [16] = '{
        12'd60,   12'd200,  12'd355,  12'd510,  12'd675,  12'd850,  12'd1030, 12'd1215,
        12'd1410, 12'd1620, 12'd1845, 12'd2080, 12'd2340, 12'd2630, 12'd2940, 12'd3275
    };

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_POP    = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_ENABLED  = 3'd0,
        REG_OFFSET   = 3'd1,
        REG_BAND     = 3'd2,
        REG_NO_KEY   = 3'd3,
        REG_IDLE_LOW = 3'd4,
        REG_TOL      = 3'd5,
        REG_POLLS    = 3'd6,
        REG_GAP      = 3'd7
    } reg_idx_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc;
        logic scan_step;
        logic update;
        logic pop_rd;
        logic pop_done;
        logic wr_center;
        logic out_load;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic enabled;
        logic scan_last;
        logic q_empty;
        logic out_free;
    } stat_t;

endpackage

// ===== src/akd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module akd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/akd_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the keypad decoder.
module akd_ctrl import akd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] s_cmd,
    input  stat_t            status,
    output ctrl_t            ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SCAN,
        ST_UPDATE,
        ST_POP_RD,
        ST_POP_OUT,
        ST_WRITE,
        ST_BLANK
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    cmd_t   cmd;

    assign cmd      = cmd_t'(s_cmd);
    assign s_tready = ready_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    ctrl.capture = 1'b1;
                    case (cmd)
                        CMD_SAMPLE: state_next = status.enabled ? ST_CALC : ST_BLANK;
                        CMD_POP:    state_next = ST_POP_RD;
                        CMD_WRITE:  state_next = ST_WRITE;
                        default:    state_next = ST_BLANK;
                    endcase
                end
            end
            ST_CALC: begin
                ctrl.calc  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                ctrl.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    ctrl.update   = 1'b1;
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_POP_RD: begin
                ctrl.pop_rd = 1'b1;
                state_next  = status.q_empty ? ST_BLANK : ST_POP_OUT;
            end
            ST_POP_OUT: begin
                if (status.out_free) begin
                    ctrl.pop_done = 1'b1;
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    ctrl.wr_center = 1'b1;
                    ctrl.out_load  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_BLANK: begin
                if (status.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ===== src/akd_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: registers, offset and clamp, centre scan, debounce, event queue, output register.
module akd_datapath import akd_pkg::*; #(
    parameter int NUM_KEYS    = DEF_NUM_KEYS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic [IN_W-1:0]   s_tdata,
    input  ctrl_t             ctrl,
    output stat_t             status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int KI_W = $clog2(NUM_KEYS);
    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    logic                enabled_reg;
    logic [OFF_W-1:0]    offset_reg;
    logic [ADC_BITS-1:0] band_reg;
    logic [ADC_BITS-1:0] no_key_reg;
    logic                idle_low_reg;
    logic [ADC_BITS-1:0] tol_reg;
    logic [CNT_W-1:0]    polls_reg;
    logic [GAP_W-1:0]    gap_reg;

    // Captured item
    logic [ADC_BITS-1:0] sample_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CIDX_W-1:0]   cidx_reg;
    logic [ADC_BITS-1:0] cval_reg;

    // Decode state
    logic [ADC_BITS-1:0] adj_reg, adj_next;
    logic                idle_reg, idle_next;
    logic                gap_ok_reg, gap_ok_next;
    logic [KI_W-1:0]     scan_idx_reg;
    logic [KI_W-1:0]     best_idx_reg;
    logic [DIST_W-1:0]   best_delta_reg;
    logic [ADC_BITS-1:0] centers_reg [NUM_KEYS];

    // Debounce and event state
    logic [KEY_W-1:0]    last_cand_reg;
    logic [CNT_W-1:0]    stable_cnt_reg, stable_cnt_next;
    logic [KEY_W-1:0]    last_stable_reg;
    logic [TIME_W-1:0]   last_time_reg;

    // Queue pointers
    logic [QP_W-1:0]     head_reg, head_inc;
    logic [QP_W-1:0]     tail_reg, tail_inc;
    logic [QC_W-1:0]     qcount_reg, qcount_push;
    logic [CIDX_W-1:0]   ram_rdata;

    // Output register
    logic                m_valid_reg;
    logic                out_det_reg, out_queued_reg, out_dropped_reg, out_pvalid_reg;
    logic [CIDX_W-1:0]   out_kidx_reg, out_pidx_reg;
    logic [LEVEL_W-1:0]  out_level_reg;

    // Combinational helpers
    logic signed [ADJ_W-1:0]  sum;
    logic signed [ADJ_W-1:0]  idle_floor;
    logic [TIME_W-1:0]        elapsed;
    logic [ADC_BITS-1:0]      center_cur;
    logic signed [DIST_W-1:0] diff;
    logic [DIST_W-1:0]        delta;
    logic                     closer;
    logic [KEY_W-1:0]         cand;
    logic                     take;
    logic                     push;
    logic                     full;

    // Offset, clamp, idle test and event gap
    always_comb begin
        sum = signed'({2'b00, sample_reg})
            + signed'({{(ADJ_W - OFF_W){offset_reg[OFF_W-1]}}, offset_reg});
        if (sum < 0) begin
            adj_next = '0;
        end else if (sum > signed'({2'b00, ADC_MAX})) begin
            adj_next = ADC_MAX;
        end else begin
            adj_next = sum[ADC_BITS-1:0];
        end
        idle_floor = signed'({2'b00, no_key_reg}) - signed'({2'b00, band_reg});
        if (idle_low_reg) begin
            idle_next = ({1'b0, adj_next} <= ({1'b0, no_key_reg} + {1'b0, band_reg}));
        end else begin
            idle_next = (signed'({2'b00, adj_next}) >= idle_floor);
        end
        elapsed     = now_reg - last_time_reg;
        gap_ok_next = (elapsed >= {{(TIME_W - GAP_W){1'b0}}, gap_reg});
    end

    // Distance to the centre under the scan pointer
    always_comb begin
        center_cur = centers_reg[scan_idx_reg];
        diff       = signed'({1'b0, adj_reg}) - signed'({1'b0, center_cur});
        delta      = (diff < 0) ? DIST_W'(-diff) : DIST_W'(diff);
        closer     = (delta < best_delta_reg);
    end

    // Candidate, debounce and push decision
    always_comb begin
        if (idle_reg || (best_delta_reg > {1'b0, tol_reg})) begin
            cand = NO_KEY;
        end else begin
            cand = KEY_W'(best_idx_reg);
        end
        if (cand == last_cand_reg) begin
            stable_cnt_next = (stable_cnt_reg < COUNT_CAP) ? stable_cnt_reg + 1'b1
                                                           : stable_cnt_reg;
        end else begin
            stable_cnt_next = CNT_W'(1);
        end
        take = (stable_cnt_next >= polls_reg) && (cand != last_stable_reg);
        push = take && (cand != NO_KEY) && gap_ok_reg;
        full = (qcount_reg >= QC_W'(QUEUE_DEPTH));
        qcount_push = full ? qcount_reg : qcount_reg + 1'b1;
        head_inc = (head_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg  <= RST_ENABLED;
            offset_reg   <= RST_OFFSET;
            band_reg     <= RST_BAND;
            no_key_reg   <= RST_NO_KEY;
            idle_low_reg <= RST_IDLE_LOW;
            tol_reg      <= RST_TOL;
            polls_reg    <= RST_POLLS;
            gap_reg      <= RST_GAP;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ENABLED:  enabled_reg  <= cfg_wdata[0];
                REG_OFFSET:   offset_reg   <= cfg_wdata[OFF_W-1:0];
                REG_BAND:     band_reg     <= cfg_wdata[ADC_BITS-1:0];
                REG_NO_KEY:   no_key_reg   <= cfg_wdata[ADC_BITS-1:0];
                REG_IDLE_LOW: idle_low_reg <= cfg_wdata[0];
                REG_TOL:      tol_reg      <= cfg_wdata[ADC_BITS-1:0];
                REG_POLLS:    polls_reg    <= cfg_wdata[CNT_W-1:0];
                REG_GAP:      gap_reg      <= cfg_wdata[GAP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Item capture and first decode stage
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            sample_reg <= s_tdata[ADC_BITS-1:0];
            now_reg    <= s_tdata[43:12];
            cidx_reg   <= s_tdata[47:44];
            cval_reg   <= s_tdata[59:48];
        end
        if (ctrl.calc) begin
            adj_reg    <= adj_next;
            idle_reg   <= idle_next;
            gap_ok_reg <= gap_ok_next;
        end
    end

    // Nearest-centre scan, one centre a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_delta_reg <= '0;
        end else if (ctrl.calc) begin
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_delta_reg <= {1'b0, ADC_MAX} + 1'b1;
        end else if (ctrl.scan_step) begin
            scan_idx_reg <= status.scan_last ? '0 : scan_idx_reg + 1'b1;
            if (closer) begin
                best_delta_reg <= delta;
                best_idx_reg   <= scan_idx_reg;
            end
        end
    end

    // Calibration centres
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                centers_reg[k] <= DEFAULT_CENTERS[k];
            end
        end else if (ctrl.wr_center) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (cidx_reg == CIDX_W'(k)) begin
                    centers_reg[k] <= cval_reg;
                end
            end
        end
    end

    // Debounce state, event time and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cand_reg   <= NO_KEY;
            stable_cnt_reg  <= '0;
            last_stable_reg <= NO_KEY;
            last_time_reg   <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            qcount_reg      <= '0;
        end else if (ctrl.update) begin
            last_cand_reg  <= cand;
            stable_cnt_reg <= stable_cnt_next;
            if (take) begin
                last_stable_reg <= cand;
            end
            if (push) begin
                last_time_reg <= now_reg;
                tail_reg      <= tail_inc;
                qcount_reg    <= qcount_push;
                if (full) begin
                    head_reg <= head_inc;
                end
            end
        end else if (ctrl.pop_done) begin
            head_reg   <= head_inc;
            qcount_reg <= qcount_reg - 1'b1;
        end
    end

    // Event store
    akd_ram #(
        .WIDTH (CIDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (ctrl.update && push),
        .waddr (tail_reg),
        .wdata (cand[CIDX_W-1:0]),
        .re    (ctrl.pop_rd),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output fields
    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_det_reg     <= 1'b0;
            out_kidx_reg    <= '0;
            out_queued_reg  <= 1'b0;
            out_dropped_reg <= 1'b0;
            out_pvalid_reg  <= 1'b0;
            out_pidx_reg    <= '0;
            out_level_reg   <= LEVEL_W'(qcount_reg);
            if (ctrl.update) begin
                out_det_reg     <= (cand != NO_KEY);
                out_kidx_reg    <= (cand != NO_KEY) ? cand[CIDX_W-1:0] : '0;
                out_queued_reg  <= push;
                out_dropped_reg <= push && full;
                out_level_reg   <= push ? LEVEL_W'(qcount_push) : LEVEL_W'(qcount_reg);
            end else if (ctrl.pop_done) begin
                out_pvalid_reg <= 1'b1;
                out_pidx_reg   <= ram_rdata;
                out_level_reg  <= LEVEL_W'(qcount_reg - 1'b1);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_level_reg, out_pidx_reg, out_pvalid_reg, out_dropped_reg,
                       out_queued_reg, out_kidx_reg, out_det_reg};

    assign status.enabled   = enabled_reg;
    assign status.scan_last = (scan_idx_reg == KI_W'(NUM_KEYS - 1));
    assign status.q_empty   = (qcount_reg == '0);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

// ===== src/analog_keypad_decoder.sv =====
`timescale 1ns / 1ps
// Resistor-ladder keypad decoder: input stream in, one result item per input item out.
//
// Input channel s_*: each item carries a command in s_tuser (sample, pop event, write centre)
// and its operands in s_tdata. Result channel m_*: one status item per input item, in order.
// A sample is offset, clamped, tested against the idle band, matched against the key
// centres, debounced and, when a new stable key passes the event gap, pushed into the
// event queue (oldest entry dropped when full). A pop returns the oldest queued key.
// An enabled sample is captured, offset and clamped, then the centre scan compares
// one centre per cycle, then the result is loaded; a pop first does the registered queue
// memory read; a centre write, a disabled sample or an unknown command loads its result
// with no further step. The result is registered and shows the cycle after the last step;
// the next item is accepted while it waits to be taken.
// When m_tready stays low, the block finishes at most one further item's decode and
// holds it until the output register frees up; s_tready then stays low.
// Reset (aresetn low, synchronous) restores register defaults and the factory centres,
// empties the event queue and clears the debounce state. The user must write registers
// on the cfg_* port only while the block is idle; the block itself does not enforce it.
module analog_keypad_decoder import akd_pkg::*; #(
    parameter int NUM_KEYS    = DEF_NUM_KEYS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // input channel
    input  logic              s_tvalid,
    output logic              s_tready,
    // adc_sample[11:0], now_ms[43:12], center_index[47:44], center_value[59:48], zero pad
    input  logic [IN_W-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]  s_tuser,
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    // key_detected[0], key_index[4:1], event_queued[5], event_dropped[6],
    // popped_valid[7], popped_index[11:8], queue_level[15:12]
    output logic [OUT_W-1:0]  m_tdata
);

    ctrl_t ctrl;
    stat_t status;

    akd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .status   (status),
        .ctrl     (ctrl)
    );

    akd_datapath #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .ctrl      (ctrl),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // One item at a time: no new item right after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in progress");

    // A result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // A pop result only completes on a non-empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop_done |-> !status.q_empty)
        else $error("pop completed without a valid queue read");

    // The scan only runs after the first decode stage or on itself
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.scan_step |-> ($past(ctrl.calc) || $past(ctrl.scan_step)))
        else $error("centre scan started without a decoded sample");

endmodule

// ===== bench/keypad_status_checker.sv =====
`timescale 1ns / 1ps
// Keypad decoder checker: tracks registers, predicts each status item and compares results.
module keypad_status_checker import akd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [CMD_W-1:0]  s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int                fail_count,
    output int                outstanding
);

    // One status item as the block reports it
    typedef struct {
        logic       detected;
        logic [3:0] key;
        logic       queued;
        logic       dropped;
        logic       popped;
        logic [3:0] popped_key;
        logic [3:0] level;
    } status_t;

    // Register copies
    logic                enabled;
    logic [OFF_W-1:0]    offset;
    logic [ADC_BITS-1:0] band;
    logic [ADC_BITS-1:0] idle_level;
    logic                idle_low;
    logic [ADC_BITS-1:0] tolerance;
    logic [CNT_W-1:0]    polls;
    logic [GAP_W-1:0]    gap_ms;

    // Decoder state
    logic [ADC_BITS-1:0] centers [16];
    logic [KEY_W-1:0]    cand_last;
    logic [KEY_W-1:0]    stable_key;
    int                  stable_run;
    logic [TIME_W-1:0]   last_event_ms;
    logic [3:0]          key_events [$];

    status_t pending_status [$];
    status_t want;
    status_t got;

    // Offset, clamp, idle band test, then nearest centre within tolerance
    function automatic logic [KEY_W-1:0] nearest_key(logic [ADC_BITS-1:0] raw);
        int adj;
        int best_d;
        int d;
        logic [KEY_W-1:0] best;
        adj = int'(raw) + int'($signed(offset));
        if (adj < 0) adj = 0;
        if (adj > int'(ADC_MAX)) adj = int'(ADC_MAX);
        if (idle_low) begin
            if (adj <= int'(idle_level) + int'(band)) return NO_KEY;
        end else begin
            if (adj >= int'(idle_level) - int'(band)) return NO_KEY;
        end
        best   = NO_KEY;
        best_d = int'(ADC_MAX) + 1;
        for (int i = 0; i < 16; i++) begin
            d = adj - int'(centers[i]);
            if (d < 0) d = -d;
            // strict compare keeps the lowest index on a tie
            if (d < best_d) begin
                best_d = d;
                best   = KEY_W'(i);
            end
        end
        if (best == NO_KEY || best_d > int'(tolerance)) return NO_KEY;
        return best;
    endfunction

    // Advance the decoder by one item and return its status
    function automatic status_t predict_status(cmd_t cmd, logic [IN_W-1:0] d);
        status_t             r;
        logic [KEY_W-1:0]    cand;
        logic [ADC_BITS-1:0] sample;
        logic [TIME_W-1:0]   now;
        logic [3:0]          ci;
        logic [ADC_BITS-1:0] cv;
        sample = d[11:0];
        now    = d[43:12];
        ci     = d[47:44];
        cv     = d[59:48];
        r = '{default: '0};
        if (cmd == CMD_SAMPLE && enabled) begin
            cand = nearest_key(sample);
            if (cand != NO_KEY) begin
                r.detected = 1'b1;
                r.key      = cand[3:0];
            end
            // debounce run, saturating
            if (cand == cand_last) begin
                if (stable_run < int'(COUNT_CAP)) stable_run++;
            end else begin
                cand_last  = cand;
                stable_run = 1;
            end
            if (stable_run >= int'(polls) && cand != stable_key) begin
                stable_key = cand;
                if (cand != NO_KEY && (now - last_event_ms) >= TIME_W'(gap_ms)) begin
                    last_event_ms = now;
                    if (key_events.size() >= DEF_QUEUE_DEPTH) begin
                        void'(key_events.pop_front());
                        r.dropped = 1'b1;
                    end
                    key_events.push_back(cand[3:0]);
                    r.queued = 1'b1;
                end
            end
        end else if (cmd == CMD_POP) begin
            if (key_events.size() != 0) begin
                r.popped     = 1'b1;
                r.popped_key = key_events.pop_front();
            end
        end else if (cmd == CMD_WRITE) begin
            centers[ci] = cv;
        end
        r.level = 4'(key_events.size());
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge aclk) begin
        if (!aresetn) begin
            enabled       = RST_ENABLED;
            offset        = RST_OFFSET;
            band          = RST_BAND;
            idle_level    = RST_NO_KEY;
            idle_low      = RST_IDLE_LOW;
            tolerance     = RST_TOL;
            polls         = RST_POLLS;
            gap_ms        = RST_GAP;
            centers       = DEFAULT_CENTERS;
            cand_last     = NO_KEY;
            stable_key    = NO_KEY;
            stable_run    = 0;
            last_event_ms = '0;
            key_events.delete();
            pending_status.delete();
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_ENABLED:  enabled    = cfg_wdata[0];
                    REG_OFFSET:   offset     = cfg_wdata[OFF_W-1:0];
                    REG_BAND:     band       = cfg_wdata[ADC_BITS-1:0];
                    REG_NO_KEY:   idle_level = cfg_wdata[ADC_BITS-1:0];
                    REG_IDLE_LOW: idle_low   = cfg_wdata[0];
                    REG_TOL:      tolerance  = cfg_wdata[ADC_BITS-1:0];
                    REG_POLLS:    polls      = cfg_wdata[CNT_W-1:0];
                    REG_GAP:      gap_ms     = cfg_wdata[GAP_W-1:0];
                    default: ;
                endcase
            end
            // results first: they belong to items accepted earlier
            if (m_tvalid && m_tready) begin
                if (pending_status.size() == 0) begin
                    $error("status item 0x%h arrived with none expected", m_tdata);
                    fail_count++;
                end else begin
                    want           = pending_status.pop_front();
                    got.detected   = m_tdata[0];
                    got.key        = m_tdata[4:1];
                    got.queued     = m_tdata[5];
                    got.dropped    = m_tdata[6];
                    got.popped     = m_tdata[7];
                    got.popped_key = m_tdata[11:8];
                    got.level      = m_tdata[15:12];
                    check_field("key_detected", want.detected, got.detected);
                    check_field("key_index", want.key, got.key);
                    check_field("event_queued", want.queued, got.queued);
                    check_field("event_dropped", want.dropped, got.dropped);
                    check_field("popped_valid", want.popped, got.popped);
                    check_field("popped_index", want.popped_key, got.popped_key);
                    check_field("queue_level", want.level, got.level);
                end
            end
            if (s_tvalid && s_tready)
                pending_status.push_back(predict_status(cmd_t'(s_tuser), s_tdata));
        end
        outstanding = pending_status.size();
    end

endmodule

// ===== bench/tb_analog_keypad_decoder.sv =====
`timescale 1ns / 1ps
// Keypad decoder testbench: clock, reset, register phases, stimulus and the verdict.
module tb_analog_keypad_decoder;
    import akd_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int LIMIT       = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 18;
    localparam int NUM_PHASES  = 7;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [CMD_W-1:0]  s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    int fails;
    int outstanding;
    int cycles = 0;
    int sent   = 0;

    // Register settings per phase: enabled, offset, idle band, no-key level, idle low,
    // tolerance, stable polls, event gap
    int phase_regs [NUM_PHASES][8] = '{
        '{1,    0,  100, 4000, 0,   80,   3,   200},
        '{1,   37,    0, 4095, 0, 4095,   1,     0},
        '{1, -512,   40,    0, 1,    0,   2,    50},
        '{1,  511,  300, 3800, 0,   60, 250, 65535},
        '{0,    5,  100, 4000, 0,   80,   3,   200},
        '{1, -100, 4095, 4095, 1,   40,   0,     1},
        '{1,    0,  100, 4000, 0,   80,   0,     1}
    };
    int phase_items [NUM_PHASES] = '{250, 200, 150, 300, 40, 40, 150};

    // Centre values the stimulus aims at, kept in step with centre writes
    logic [ADC_BITS-1:0] aim [16];
    int                  cur_off;
    int                  cur_tol;
    int                  cur_polls;
    logic                cur_idle_low;
    logic [TIME_W-1:0]   now_ms;
    bit                  quiet;
    bit                  hold_req;
    bit                  held;

    analog_keypad_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    keypad_status_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fails),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** analog_keypad_decoder: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        held     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held = 1'b1;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic int adc_clamp(int v);
        return (v < 0) ? 0 : ((v > int'(ADC_MAX)) ? int'(ADC_MAX) : v);
    endfunction

    // Offer one item after a random gap; returns at the accepting edge with tvalid high
    task automatic send_item(cmd_t cmd, logic [11:0] sample, logic [3:0] cidx,
                             logic [11:0] cval);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, cval, cidx, now_ms, sample};
        if (cmd == CMD_WRITE) aim[cidx] = cval;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic sample_at(logic [TIME_W-1:0] t, logic [11:0] s);
        now_ms = t;
        send_item(CMD_SAMPLE, s, 4'($urandom), 12'($urandom));
    endtask

    // Sample with a random time step: mostly small, sometimes none, rarely a jump
    task automatic tick_sample(logic [11:0] s);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            now_ms = $urandom;
        else if (r >= 5)
            now_ms += $urandom_range(1, 40);
        send_item(CMD_SAMPLE, s, 4'($urandom), 12'($urandom));
    endtask

    task automatic send_pop();
        send_item(CMD_POP, 12'($urandom), 4'($urandom), 12'($urandom));
    endtask

    // Key held near its centre, then released to the idle level; some presses cut short
    task automatic press_key();
        int k;
        int len;
        int j;
        k   = $urandom_range(0, 15);
        j   = (cur_tol < 20) ? cur_tol : 20;
        len = ((cur_polls < 1) ? 1 : cur_polls) + $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
        repeat (len)
            tick_sample(12'(adc_clamp(int'(aim[k]) - cur_off
                                      + int'($urandom_range(0, 2 * j)) - j)));
        len = ((cur_polls < 1) ? 1 : cur_polls) + $urandom_range(0, 3);
        repeat (len)
            tick_sample(cur_idle_low ? 12'($urandom_range(0, 20))
                                     : 12'($urandom_range(4075, 4095)));
    endtask

    task automatic write_reg(reg_idx_t idx, int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DW'(val);
    endtask

    // Drain, then load a full register set while the block is idle
    task automatic set_phase(int p);
        stop_sending();
        wait (outstanding == 0);
        repeat (4) @(negedge aclk);
        write_reg(REG_ENABLED,  phase_regs[p][0]);
        write_reg(REG_OFFSET,   phase_regs[p][1]);
        write_reg(REG_BAND,     phase_regs[p][2]);
        write_reg(REG_NO_KEY,   phase_regs[p][3]);
        write_reg(REG_IDLE_LOW, phase_regs[p][4]);
        write_reg(REG_TOL,      phase_regs[p][5]);
        write_reg(REG_POLLS,    phase_regs[p][6]);
        write_reg(REG_GAP,      phase_regs[p][7]);
        @(negedge aclk);
        cfg_we       <= 1'b0;
        cur_off      = phase_regs[p][1];
        cur_idle_low = phase_regs[p][4][0];
        cur_tol      = phase_regs[p][5];
        cur_polls    = phase_regs[p][6];
    endtask

    initial begin
        int r;
        int idx;
        int phase_start;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_ENABLED;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_SAMPLE;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        now_ms       = '0;
        aim          = DEFAULT_CENTERS;
        cur_off      = 0;
        cur_tol      = int'(RST_TOL);
        cur_polls    = int'(RST_POLLS);
        cur_idle_low = RST_IDLE_LOW;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on reset settings
        send_pop();                         // pop on an empty queue
        sample_at(0, 12'd60);               // first key: blocked by the gap from time zero
        sample_at(10, 12'd60);
        sample_at(20, 12'd60);
        sample_at(30, 12'd4095);            // idle at the top of the range
        sample_at(40, 12'd4095);
        sample_at(50, 12'd4095);
        sample_at(60, 12'd0);               // bottom of the range still matches key 0
        sample_at(70, 12'd130);             // equal distance to keys 0 and 1
        sample_at(300, 12'd60);             // event queued
        sample_at(310, 12'd3500);           // outside the tolerance
        sample_at(320, 12'd3275);           // stable key 15, too close to last event
        sample_at(330, 12'd3275);
        sample_at(340, 12'd3275);
        sample_at(600, 12'd2630);           // event for key 13
        sample_at(610, 12'd2630);
        sample_at(620, 12'd2630);
        send_item(CMD_NONE, 12'($urandom), 4'($urandom), 12'($urandom));
        send_item(CMD_WRITE, 12'($urandom), 4'd15, 12'd4095);
        send_item(CMD_WRITE, 12'($urandom), 4'd0, 12'd0);
        sample_at(32'hFFFF_FFFF, 12'd4095);
        send_pop();
        send_pop();
        send_pop();

        // Random part, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(p);
            if (p == 0) begin
                now_ms   = 32'hFFFF_C000;   // wraps during the run
                hold_req = 1'b1;
            end
            quiet       = (p == 1);
            phase_start = sent;
            while (sent - phase_start < phase_items[p]) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    press_key();
                end else if (r < 82) begin
                    repeat ($urandom_range(1, 5)) tick_sample(12'($urandom_range(0, 4095)));
                end else if (r < 93) begin
                    repeat ($urandom_range(1, 10)) send_pop();
                end else if (r < 97) begin
                    idx = $urandom_range(0, 15);
                    send_item(CMD_WRITE, 12'($urandom), 4'(idx),
                              ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4095))
                              : 12'(adc_clamp(int'(aim[idx]) + int'($urandom_range(0, 40)) - 20)));
                end else begin
                    send_item(CMD_NONE, 12'($urandom), 4'($urandom), 12'($urandom));
                end
            end
        end
        quiet = 1'b0;

        // Drain and give the verdict
        stop_sending();
        wait (outstanding == 0);
        repeat (50) @(posedge aclk);
        if (fails == 0)
            $display("** analog_keypad_decoder: PASSED **");
        else
            $display("** analog_keypad_decoder: FAILED **");
        $finish;
    end

endmodule
